### design/mmrq_pkg.sv
package mmrq_pkg;
  localparam int BRANCH_DEF = 4;
  localparam int MAX_LEVELS_DEF = 7;
  localparam int CAPACITY_DEF = 4096;
  localparam int SAMPLE_WIDTH_DEF = 32;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
endpackage

### design/multilevel_min_max_range_query.sv
// Channel | Direction | Request contents (tdata low bit up)
// in_     | slave     | sample[31:0], range_left[43:32], range_right[55:44], opcode in tuser[1:0]
// out_    | master    | min_value[31:0], max_value[63:32], empty_res[64], full_res[65]
//
// An append writes the raw sample, then at each level either opens a bucket (pick, write)
// or merges into one (pick, load, read, write), and ends with a pick alone when the climb
// reaches a level without buckets. A query takes one sample or bucket per step: it tries
// levels from the top down until one fits, then reads and merges the chosen entry.
// An invalid query or dropped append answers the cycle after it is taken; clear and the
// unused opcode answer nothing. Synchronous active-low reset clears the count, the dropped
// flag and control; the stores need no clearing. The block takes no request while one is
// in work or its result waits on out_tready.
module multilevel_min_max_range_query
  import mmrq_pkg::*;
#(
  parameter int BRANCH = BRANCH_DEF,  // must be a power of two
  parameter int MAX_LEVELS = MAX_LEVELS_DEF,
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,  // sample, range_left, range_right
  input  logic [1:0]  in_tuser,  // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata  // min_value, max_value, empty_res, full_res
);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(2 * CAPACITY);
  localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int GW = 32;
  localparam int BB = $clog2(BRANCH);

  // Geometry per level: bucket span as a shift, span, bucket count and base address.
  typedef logic [GW-1:0] geo_t [MAX_LEVELS];
  function automatic geo_t mk_shift();
    geo_t g;
    for (int i = 0; i < MAX_LEVELS; i++) g[i] = GW'(BB * (i + 1));
    return g;
  endfunction
  function automatic geo_t mk_step();
    geo_t g;
    for (int i = 0; i < MAX_LEVELS; i++) g[i] = GW'(1) << (BB * (i + 1));
    return g;
  endfunction
  function automatic geo_t mk_cnt();
    geo_t g;
    for (int i = 0; i < MAX_LEVELS; i++) g[i] = GW'(CAPACITY >> (BB * (i + 1)));
    return g;
  endfunction
  function automatic geo_t mk_base();
    geo_t g;
    int b;
    b = 0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      g[i] = GW'(b);
      b = b + (CAPACITY >> (BB * (i + 1)));
    end
    return g;
  endfunction
  localparam geo_t SHIFT = mk_shift();
  localparam geo_t STEP = mk_step();
  localparam geo_t NBKT = mk_cnt();
  localparam geo_t BASE = mk_base();

  localparam logic [3:0] S_IDLE = 4'd0, S_AW = 4'd1, S_AL = 4'd2, S_ARD = 4'd3,
                         S_AWB = 4'd4, S_QS = 4'd5, S_QR = 4'd6, S_QA = 4'd7,
                         S_OUT = 4'd8, S_APICK = 4'd9, S_QC = 4'd10;

  // Store: raw samples at 0..CAPACITY-1, buckets from CAPACITY upward.
  logic [2*SW-1:0] mem [2*CAPACITY];
  logic [2*SW-1:0] rd_r;
  logic [AW-1:0]   addr_r;
  logic            we;
  logic [2*SW-1:0] wd;

  logic [3:0]    st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          drop_r, drop_nxt;
  logic [CW-1:0] idx_r, idx_nxt;  // append index or query cursor
  logic [CW-1:0] rgt_r, rgt_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [SW-1:0] cmin_r, cmin_nxt, cmax_r, cmax_nxt;
  logic          have_r, have_nxt, emp_r, emp_nxt;
  logic [CW-1:0] adv_r, adv_nxt;
  logic [AW-1:0] addr_nxt;
  logic          ovld_r, ovld_nxt;

  always_ff @(posedge clk) begin
    if (we) mem[addr_r] <= wd;
    rd_r <= mem[addr_r];
  end

  // Per-level bucket tests at the current index; spans are powers of two.
  logic [GW-1:0] idx_g, idx1_g, rgt_g, msk, kk;
  logic          fits;
  logic          first;
  logic          last;
  assign idx_g  = GW'(idx_r);
  assign idx1_g = GW'(idx_r) + GW'(1);
  assign rgt_g  = GW'(rgt_r);
  always_comb begin
    msk   = STEP[lvl_r] - GW'(1);
    kk    = idx_g >> SHIFT[lvl_r];
    first = (lvl_r == '0) ? ((idx_g & msk) == '0)
          : ((idx1_g & msk) == (STEP[lvl_r] >> BB));
    last  = ((idx1_g & msk) == '0);
    fits  = ((idx_g & msk) == '0) && (idx_g + msk <= rgt_g) && (kk < NBKT[lvl_r]);
  end

  logic signed [SW-1:0] rmn, rmx;
  assign rmn = rd_r[SW-1:0];
  assign rmx = rd_r[2*SW-1:SW];

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; drop_nxt = drop_r; idx_nxt = idx_r;
    rgt_nxt = rgt_r; lvl_nxt = lvl_r; cmin_nxt = cmin_r; cmax_nxt = cmax_r;
    have_nxt = have_r; emp_nxt = emp_r; adv_nxt = adv_r; addr_nxt = addr_r;
    ovld_nxt = ovld_r; we = 1'b0; wd = {cmax_r, cmin_r};
    unique case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          emp_nxt = 1'b0; cmin_nxt = '0; cmax_nxt = '0; have_nxt = 1'b0;
          unique case (in_tuser)
            OP_APPEND: begin
              if (cnt_r >= CW'(CAPACITY)) begin
                drop_nxt = 1'b1; st_nxt = S_OUT; ovld_nxt = 1'b1;
              end else begin
                cmin_nxt = in_tdata[SW-1:0]; cmax_nxt = in_tdata[SW-1:0];
                idx_nxt = cnt_r; addr_nxt = AW'(cnt_r); lvl_nxt = '0;
                st_nxt = S_AW;
              end
            end
            OP_QUERY: begin
              if (in_tdata[43:32] > in_tdata[55:44] ||
                  GW'(in_tdata[55:44]) >= GW'(cnt_r)) begin
                emp_nxt = 1'b1; st_nxt = S_OUT; ovld_nxt = 1'b1;
              end else begin
                idx_nxt = CW'(in_tdata[43:32]); rgt_nxt = CW'(in_tdata[55:44]);
                st_nxt = S_QS;
              end
            end
            OP_CLEAR: begin
              cnt_nxt = '0; drop_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      // Append: write the raw sample, then walk levels.
      S_AW: begin
        we = 1'b1; cnt_nxt = cnt_r + 1'b1;
        st_nxt = S_APICK;
      end
      S_APICK: begin
        addr_nxt = AW'(CAPACITY) + AW'(BASE[lvl_r] + kk);
        if (kk >= NBKT[lvl_r]) begin
          st_nxt = S_OUT; ovld_nxt = 1'b1; cmin_nxt = '0; cmax_nxt = '0;
        end else st_nxt = first ? S_AWB : S_AL;
      end
      S_AL: st_nxt = S_ARD;
      S_ARD: begin
        if ($signed(rmn) < $signed(cmin_r)) cmin_nxt = rmn; else cmin_nxt = cmin_r;
        if ($signed(rmx) > $signed(cmax_r)) cmax_nxt = rmx; else cmax_nxt = cmax_r;
        st_nxt = S_AWB;
      end
      S_AWB: begin
        we = 1'b1;
        if (!last || lvl_r == LW'(MAX_LEVELS - 1)) begin
          st_nxt = S_OUT; ovld_nxt = 1'b1; cmin_nxt = '0; cmax_nxt = '0;
        end else begin
          lvl_nxt = lvl_r + 1'b1; st_nxt = S_APICK;
        end
      end
      // Query: pick the largest fitting bucket, one level per cycle.
      S_QS: begin
        lvl_nxt = LW'(MAX_LEVELS - 1); st_nxt = S_QA;
        addr_nxt = AW'(idx_r); adv_nxt = CW'(1);
      end
      S_QA: begin
        if (fits) begin
          addr_nxt = AW'(CAPACITY) + AW'(BASE[lvl_r] + kk);
          adv_nxt = CW'(STEP[lvl_r]); st_nxt = S_QR;
        end else if (lvl_r == '0) st_nxt = S_QR;
        else lvl_nxt = lvl_r - 1'b1;
      end
      S_QR: st_nxt = S_QC;
      S_QC: begin
        if (!have_r || $signed(rmn) < $signed(cmin_r)) cmin_nxt = rmn;
        if (!have_r || $signed(rmx) > $signed(cmax_r)) cmax_nxt = rmx;
        have_nxt = 1'b1;
        if ({1'b0, idx_r} + {1'b0, adv_r} > {1'b0, rgt_r}) begin
          st_nxt = S_OUT; ovld_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + adv_r; st_nxt = S_QS;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          ovld_nxt = 1'b0; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; drop_r <= 1'b0; ovld_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; drop_r <= drop_nxt; ovld_r <= ovld_nxt;
    end
  end
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; rgt_r <= rgt_nxt; lvl_r <= lvl_nxt; cmin_r <= cmin_nxt;
    cmax_r <= cmax_nxt; have_r <= have_nxt; emp_r <= emp_nxt; adv_r <= adv_nxt;
    addr_r <= addr_nxt;
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = ovld_r;
  assign out_tdata  = {6'd0, drop_r, emp_r, cmax_r, cmin_r};
endmodule
